[design/rvm_pkg.sv]
`default_nettype none
package rvm_pkg;

  localparam int unsigned XLEN = 64;
  localparam int unsigned OP_W = 3;
  localparam int unsigned QUEUE_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_MUL    = 3'd0,
    OP_MULH   = 3'd1,
    OP_MULHSU = 3'd2,
    OP_MULHU  = 3'd3,
    OP_DIV    = 3'd4,
    OP_DIVU   = 3'd5,
    OP_REM    = 3'd6,
    OP_REMU   = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    CLS_MUL   = 2'd0,
    CLS_DIV   = 2'd1,
    CLS_FIXED = 2'd2
  } cls_t;

  // Back-end execution states.
  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL_SUM, ST_DIV, ST_DIV_FIX, ST_DONE
  } bst_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    cls_t            cls;
    logic            word;
    logic            hi;        // keep the high half of the product
    logic            want_rem;
    logic            neg_q;     // negate magnitude quotient
    logic            neg_r;     // negate magnitude remainder
    logic [XLEN-1:0] mag_a;     // operand magnitudes (unsigned work)
    logic [XLEN-1:0] mag_b;
    logic [XLEN-1:0] fixed_val; // result when no arithmetic is needed
    logic            illegal;
    logic            neg_p;     // negate product (signed high multiply)
  } req_t;

endpackage
`default_nettype wire

[design/rv64m_mul_div_unit.sv]
`default_nettype none
// RV64M multiply/divide unit.
// Input channel: push/full queue interface carrying op, word_form,
// operand_a and operand_b. A transaction is taken when push is high and
// full is low. Result channel: result_value and illegal_op are valid while
// empty is low; pop takes the transaction.
// The front classifies each request (signs, divide by zero, overflow,
// illegal word-form high multiplies) and writes it into a QUEUE_DEPTH entry
// queue, one per cycle while the queue has room.
// The back executes one request at a time, in these steps:
//   multiply: leave the queue with partial products, then sum
//   divide:   leave the queue, 64 radix-2 restoring steps, fixup
//   special cases (zero divisor, overflow, illegal): fixed result only
// The back frees in the cycle after the pop, so it takes no new request
// until the last result has been popped.
// The back's single result register holds its transaction until popped;
// the front keeps accepting until the queue fills, then raises full.
// Reset empties the queue and returns the back to idle; no result is shown.
module rv64m_mul_div_unit #(
  parameter int unsigned DEPTH = rvm_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  op,
  input  wire logic        word_form,
  input  wire logic [63:0] operand_a,
  input  wire logic [63:0] operand_b,
  output logic             empty,
  input  wire logic        pop,
  output logic [63:0]      result_value,
  output logic             illegal_op
);
  import rvm_pkg::*;

  req_t req;
  logic req_valid;
  logic req_take;

  rvm_front #(.DEPTH(DEPTH)) u_front (
    .clk, .rst, .push, .full, .op, .word_form, .operand_a, .operand_b,
    .req_valid, .req_take, .req
  );

  rvm_back u_back (
    .clk, .rst, .req_valid, .req_take, .req, .empty, .pop,
    .result_value, .illegal_op
  );

endmodule
`default_nettype wire

[design/rvm_front.sv]
`default_nettype none
module rvm_front #(
  parameter int unsigned DEPTH = rvm_pkg::QUEUE_DEPTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    push,
  output logic                         full,
  input  wire logic [2:0]              op,
  input  wire logic                    word_form,
  input  wire logic [63:0]             operand_a,
  input  wire logic [63:0]             operand_b,
  output logic                         req_valid,
  input  wire logic                    req_take,
  output rvm_pkg::req_t                req
);
  import rvm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  req_t            cls_req;
  req_t            mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            do_push;
  logic            do_pop;
  logic [63:0]     sa, sb;
  logic            na, nb, a_min, b_m1, b_zero;
  op_t             opc;

  assign opc = op_t'(op);

  // Classify: sign handling, special cases of division, illegal word-form high multiplies.
  always_comb begin
    sa = word_form ? {{32{operand_a[31]}}, operand_a[31:0]} : operand_a;
    sb = word_form ? {{32{operand_b[31]}}, operand_b[31:0]} : operand_b;
    if (word_form && (opc == OP_DIVU || opc == OP_REMU || opc == OP_MUL)) begin
      sa = {32'd0, operand_a[31:0]};
      sb = {32'd0, operand_b[31:0]};
    end
    na = sa[63];
    nb = sb[63];
    b_zero = (sb == 64'd0);
    b_m1 = (sb == '1);
    a_min = word_form ? (sa == 64'hFFFF_FFFF_8000_0000) : (sa == 64'h8000_0000_0000_0000);
    cls_req = '0;
    cls_req.word = word_form;
    cls_req.mag_a = sa;
    cls_req.mag_b = sb;
    unique case (opc)
      OP_MUL: cls_req.cls = CLS_MUL;
      OP_MULH, OP_MULHSU, OP_MULHU: begin
        if (word_form) begin
          cls_req.cls = CLS_FIXED;
          cls_req.illegal = 1'b1;
        end else begin
          cls_req.cls = CLS_MUL;
          cls_req.hi = 1'b1;
          if (opc != OP_MULHU && na) begin
            cls_req.mag_a = -sa;
            cls_req.neg_p = 1'b1;
          end
          if (opc == OP_MULH && nb) begin
            cls_req.mag_b = -sb;
            cls_req.neg_p = ~cls_req.neg_p;
          end
        end
      end
      OP_DIV, OP_REM: begin
        cls_req.want_rem = (opc == OP_REM);
        if (b_zero) begin
          cls_req.cls = CLS_FIXED;
          cls_req.fixed_val = cls_req.want_rem ? sa : '1;
        end else if (a_min && b_m1) begin
          cls_req.cls = CLS_FIXED;
          cls_req.fixed_val = cls_req.want_rem ? 64'd0 : sa;
        end else begin
          cls_req.cls = CLS_DIV;
          cls_req.mag_a = na ? -sa : sa;
          cls_req.mag_b = nb ? -sb : sb;
          cls_req.neg_q = na ^ nb;
          cls_req.neg_r = na;
        end
      end
      OP_DIVU, OP_REMU: begin
        cls_req.want_rem = (opc == OP_REMU);
        if (b_zero) begin
          cls_req.cls = CLS_FIXED;
          // word-form remainder still sign-extends the low half of the dividend
          cls_req.fixed_val = cls_req.want_rem ?
                              (word_form ? {{32{sa[31]}}, sa[31:0]} : sa) : '1;
        end else begin
          cls_req.cls = CLS_DIV;
        end
      end
      default: cls_req.cls = CLS_FIXED;
    endcase
  end

  assign full = (count == (AW+1)'(DEPTH));
  assign do_push = push && !full;
  assign req_valid = (count != '0);
  assign do_pop = req_valid && req_take;
  assign req = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= cls_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

[design/rvm_back.sv]
`default_nettype none
module rvm_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_take,
  input  wire rvm_pkg::req_t req,
  output logic               empty,
  input  wire logic          pop,
  output logic [63:0]        result_value,
  output logic               illegal_op
);
  import rvm_pkg::*;

  // Multiply: 64x64 split into four 32x32 partials, one stage; sum next stage.
  // Divide: restoring radix-2, one quotient bit per cycle.
  bst_t        state, state_next;
  req_t        cur;
  logic [63:0] pp_ll, pp_lh, pp_hl, pp_hh;
  logic [63:0] rem, quo;
  logic [6:0]  cnt;
  logic [64:0] trial;
  logic [127:0] prod;
  logic [63:0] res_pick;
  logic        take;

  assign take = (state == ST_IDLE) && req_valid;
  assign req_take = take;
  assign empty = (state != ST_DONE);
  assign trial = {rem, quo[63]} - {1'b0, cur.mag_b};

  always_comb begin
    prod = {64'd0, pp_ll} + {32'd0, pp_lh, 32'd0} + {32'd0, pp_hl, 32'd0}
         + {pp_hh, 64'd0};
    if (cur.neg_p) begin
      prod = -prod;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          unique case (req.cls)
            CLS_MUL: state_next = ST_MUL_SUM;
            CLS_DIV: state_next = ST_DIV;
            default: state_next = ST_DONE;
          endcase
        end
      end
      ST_MUL_SUM: state_next = ST_DONE;
      ST_DIV:     state_next = (cnt == 7'd63) ? ST_DIV_FIX : ST_DIV;
      ST_DIV_FIX: state_next = ST_DONE;
      ST_DONE:    state_next = pop ? ST_IDLE : ST_DONE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    res_pick = cur.want_rem ? (cur.neg_r ? -rem : rem) : (cur.neg_q ? -quo : quo);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cur <= req;
          pp_ll <= req.mag_a[31:0] * req.mag_b[31:0];
          pp_lh <= req.mag_a[31:0] * req.mag_b[63:32];
          pp_hl <= req.mag_a[63:32] * req.mag_b[31:0];
          pp_hh <= req.mag_a[63:32] * req.mag_b[63:32];
          rem <= '0;
          quo <= req.mag_a;
          cnt <= '0;
          result_value <= req.fixed_val;
          illegal_op <= req.illegal;
        end
      end
      ST_MUL_SUM: begin
        if (cur.hi) begin
          result_value <= prod[127:64];
        end else if (cur.word) begin
          result_value <= {{32{prod[31]}}, prod[31:0]};
        end else begin
          result_value <= prod[63:0];
        end
        illegal_op <= 1'b0;
      end
      ST_DIV: begin
        cnt <= cnt + 7'd1;
        if (!trial[64]) begin
          rem <= trial[63:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[62:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
      end
      ST_DIV_FIX: begin
        result_value <= cur.word ? {{32{res_pick[31]}}, res_pick[31:0]} : res_pick;
        illegal_op <= 1'b0;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

[design/rvm_checker.sv]
`default_nettype none
module rvm_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic [63:0] result_value,
  input wire logic        illegal_op
);
  // A waiting result holds until popped.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result_value) && $stable(illegal_op)))
    else $error("result changed while stalled");

  // Illegal results carry zero.
  a_ill_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && illegal_op) |-> (result_value == 64'd0))
    else $error("illegal result not zero");

  // Nothing is shown right after reset.
  a_rst_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result after reset");

  // Queue cannot be full right after reset.
  a_rst_full: assert property (@(posedge clk) rst |=> !full)
    else $error("full after reset");
endmodule

bind rv64m_mul_div_unit rvm_checker u_checker (
  .clk, .rst, .full, .empty, .pop, .result_value, .illegal_op
);
`default_nettype wire

[bench/tb.sv]
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: holds expected results in issue order, computes them from each
// accepted request, and compares each popped result field by field.
class muldiv_scoreboard;
  typedef struct packed {
    logic [63:0] value;
    logic        illegal;
  } outcome_t;

  outcome_t pending[$];
  int errors;
  int checked;

  function logic [63:0] sext_word(logic [63:0] v);
    return {{32{v[31]}}, v[31:0]};
  endfunction

  // Signed divide/remainder on raw bit patterns with RISC-V corner rules.
  function logic [63:0] signed_divrem(logic [63:0] a, logic [63:0] b, bit rem);
    logic [63:0] ma, mb, q, r;
    if (b == 64'd0) return rem ? a : '1;
    if (a == {1'b1, 63'd0} && b == '1) return rem ? 64'd0 : a;
    ma = a[63] ? -a : a;
    mb = b[63] ? -b : b;
    q = ma / mb;
    r = ma % mb;
    if (rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function logic [63:0] unsigned_divrem(logic [63:0] a, logic [63:0] b, bit rem);
    if (b == 64'd0) return rem ? a : '1;
    return rem ? a % b : a / b;
  endfunction

  function outcome_t compute(rvm_pkg::op_t op, bit word, logic [63:0] a,
                             logic [63:0] b);
    outcome_t o;
    logic [127:0] prod;
    logic [63:0] sa, sb, za, zb;
    o.illegal = 1'b0;
    o.value = '0;
    if (!word) begin
      case (op)
        rvm_pkg::OP_MUL: o.value = a * b;
        rvm_pkg::OP_MULH: begin
          prod = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
          o.value = prod[127:64];
        end
        rvm_pkg::OP_MULHSU: begin
          prod = {{64{a[63]}}, a} * {64'd0, b};
          o.value = prod[127:64];
        end
        rvm_pkg::OP_MULHU: begin
          prod = {64'd0, a} * {64'd0, b};
          o.value = prod[127:64];
        end
        rvm_pkg::OP_DIV:  o.value = signed_divrem(a, b, 0);
        rvm_pkg::OP_DIVU: o.value = unsigned_divrem(a, b, 0);
        rvm_pkg::OP_REM:  o.value = signed_divrem(a, b, 1);
        default:          o.value = unsigned_divrem(a, b, 1);
      endcase
    end else begin
      sa = sext_word(a);
      sb = sext_word(b);
      za = {32'd0, a[31:0]};
      zb = {32'd0, b[31:0]};
      case (op)
        rvm_pkg::OP_MUL: o.value = sext_word(za * zb);
        rvm_pkg::OP_MULH, rvm_pkg::OP_MULHSU, rvm_pkg::OP_MULHU: o.illegal = 1'b1;
        rvm_pkg::OP_DIV:  o.value = sext_word(signed_divrem(sa, sb, 0));
        rvm_pkg::OP_DIVU: o.value = sext_word(unsigned_divrem(za, zb, 0));
        rvm_pkg::OP_REM:  o.value = sext_word(signed_divrem(sa, sb, 1));
        default:          o.value = sext_word(unsigned_divrem(za, zb, 1));
      endcase
    end
    return o;
  endfunction

  function void note_request(rvm_pkg::op_t op, bit word, logic [63:0] a,
                             logic [63:0] b);
    pending.push_back(compute(op, word, a, b));
  endfunction

  function void report(string what);
    $display("error at %0t: %s", $time, what);
    errors++;
  endfunction

  function void check_result(logic [63:0] value, logic illegal);
    outcome_t e;
    if (pending.size() == 0) begin
      report($sformatf("result %h with no request outstanding", value));
      return;
    end
    e = pending.pop_front();
    checked++;
    if (value !== e.value)
      report($sformatf("result_value %h, predicted %h", value, e.value));
    if (illegal !== e.illegal)
      report($sformatf("illegal_op %b, predicted %b", illegal, e.illegal));
  endfunction
endclass

module tb;
  import rvm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned RANDOM_ITEMS = 950;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [2:0]  op;
  logic        word_form;
  logic [63:0] operand_a;
  logic [63:0] operand_b;
  logic        empty;
  logic        pop;
  logic [63:0] result_value;
  logic        illegal_op;

  muldiv_scoreboard board;
  int unsigned cycle_count;
  int unsigned sent;
  bit          steady_pop;   // when set, the result side never stalls

  rv64m_mul_div_unit i_dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .op(op),
    .word_form(word_form), .operand_a(operand_a), .operand_b(operand_b),
    .empty(empty), .pop(pop), .result_value(result_value),
    .illegal_op(illegal_op)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hold reset at the start; never assert it again.
  initial begin
    board = new();
    rst = 1'b1;
    push = 1'b0;
    pop = 1'b0;
    op = OP_MUL;
    word_form = 1'b0;
    operand_a = '0;
    operand_b = '0;
    steady_pop = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Watchdog: end the run as failed if it runs far past the slowest case.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("rv64m_mul_div_unit: mismatch");
      $finish;
    end
  end

  // Result side: sample the handshake at the edge, then pick the next pop.
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) board.check_result(result_value, illegal_op);
      pop <= steady_pop || ($urandom_range(99) >= 13);
    end
  end

  // Pick an operand that favors the corners: zero, one, all ones, sign bits.
  function automatic logic [63:0] pick_operand();
    case ($urandom_range(9))
      0: return 64'd0;
      1: return 64'd1;
      2: return '1;
      3: return {1'b1, 63'd0};
      4: return {32'hffff_ffff, 1'b1, 31'd0};
      5: return {32'd0, 1'b1, 31'd0};
      6: return {$urandom, $urandom} >> $urandom_range(63);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Present one transaction and hold it until the unit takes it.
  task automatic send(op_t o, bit w, logic [63:0] a, logic [63:0] b, bit may_idle);
    while (may_idle && $urandom_range(99) < 13) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    op <= o;
    word_form <= w;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk); while (full);
    board.note_request(o, w, a, b);
    sent++;
  endtask

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    op_t o;
    @(negedge rst);
    @(posedge clk);

    // Directed: every operation in both forms, divide by zero, overflow.
    for (int k = 0; k < 8; k++) begin
      o = op_t'(k);
      send(o, 1'b0, {1'b1, 63'd0}, '1, 1'b0);
      send(o, 1'b1, {32'd0, 1'b1, 31'd0}, 64'hffff_ffff, 1'b0);
    end
    send(OP_DIV, 1'b0, 64'd12345, 64'd0, 1'b0);
    send(OP_REMU, 1'b1, '1, 64'hffff_ffff_0000_0000, 1'b0);
    send(OP_MULHU, 1'b0, '1, '1, 1'b0);
    send(OP_REM, 1'b0, 64'hffff_ffff_ffff_fff9, 64'd2, 1'b0);
    send(OP_MUL, 1'b1, 64'h7fff_ffff, 64'h7fff_ffff, 1'b0);

    // Pause the sender until every outstanding result has come back.
    push <= 1'b0;
    drain();

    // Random: first stretch with no idling on either side, then random gaps.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady_pop = (n < 150);
      send(op_t'($urandom_range(7)), $urandom_range(1), pick_operand(),
           pick_operand(), n >= 150);
    end
    push <= 1'b0;
    steady_pop = 1'b0;
    drain();
    repeat (100) @(posedge clk);

    $display("sent %0d requests across all operations and both forms, %0d results checked",
             sent, board.checked);
    $display("corners: zero divisor, signed overflow, word-form high multiply");
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("rv64m_mul_div_unit: match");
    end else begin
      $display("rv64m_mul_div_unit: mismatch");
    end
    $finish;
  end
endmodule

`default_nettype wire
